FILE: hdl/bdf_pkg.sv
// types, constants and the double-dabble step shared by the bcd display formatter
// no dependencies; compile first
`default_nettype none

package bdf_pkg;

   localparam int DIGIT_COUNT = 10;
   localparam int DIGIT_W     = 4;
   localparam int BCD_W       = DIGIT_COUNT * DIGIT_W;
   localparam int NUMBER_W    = 31;
   localparam int FIELD_AB_W  = 7;
   localparam int FIELD_C_W   = 14;
   localparam int AB_BCD_W    = 3 * DIGIT_W;
   localparam int C_BCD_W     = 5 * DIGIT_W;
   localparam int REQ_DATA_W  = 64;
   localparam int REQ_USER_W  = 2;

   localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'hF;

   typedef enum logic [1:0] {
      KIND_NUMBER = 2'd0,
      KIND_TIME   = 2'd1,
      KIND_DATE   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      BLINK_NONE = 2'd0,
      BLINK_A    = 2'd1,
      BLINK_B    = 2'd2,
      BLINK_C    = 2'd3
   } blink_type;

   typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits_type;

   // one pipeline stage: binary left to shift in and bcd built so far, per lane
   typedef struct packed {
      kind_type                kind;
      blink_type               blink_sel;
      logic                    blink_phase;
      logic [NUMBER_W-1:0]     num_bin;
      logic [BCD_W-1:0]        num_bcd;
      logic [FIELD_AB_W-1:0]   a_bin;
      logic [AB_BCD_W-1:0]     a_bcd;
      logic [FIELD_AB_W-1:0]   b_bin;
      logic [AB_BCD_W-1:0]     b_bcd;
      logic [FIELD_C_W-1:0]    c_bin;
      logic [C_BCD_W-1:0]      c_bcd;
   } conv_type;

   // add 3 to every digit of 5 or more, then shift one binary bit in
   function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                input logic bit_in);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (bcd[DIGIT_W*d +: DIGIT_W] >= 4'd5) begin
            adj[DIGIT_W*d +: DIGIT_W] = bcd[DIGIT_W*d +: DIGIT_W] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

endpackage

`default_nettype wire

FILE: hdl/bdf_dabble_stage.sv
// one combinational slice of the shift-and-add-3 conversion, per lane a set number of shifts
// depends on bdf_pkg
`default_nettype none

module bdf_dabble_stage #(
   parameter int NUM_SHIFTS = 8,
   parameter int C_SHIFTS   = 0,
   parameter int AB_SHIFTS  = 0
) (
   input  bdf_pkg::conv_type stage_i,
   output bdf_pkg::conv_type stage_o
);
   import bdf_pkg::*;

   always_comb begin
      stage_o = stage_i;
      for (int i = 0; i < NUM_SHIFTS; i++) begin
         stage_o.num_bcd = dd_step(stage_o.num_bcd, stage_o.num_bin[NUMBER_W-1]);
         stage_o.num_bin = {stage_o.num_bin[NUMBER_W-2:0], 1'b0};
      end
      for (int i = 0; i < C_SHIFTS; i++) begin
         stage_o.c_bcd = C_BCD_W'(dd_step(BCD_W'(stage_o.c_bcd), stage_o.c_bin[FIELD_C_W-1]));
         stage_o.c_bin = {stage_o.c_bin[FIELD_C_W-2:0], 1'b0};
      end
      for (int i = 0; i < AB_SHIFTS; i++) begin
         stage_o.a_bcd = AB_BCD_W'(dd_step(BCD_W'(stage_o.a_bcd), stage_o.a_bin[FIELD_AB_W-1]));
         stage_o.a_bin = {stage_o.a_bin[FIELD_AB_W-2:0], 1'b0};
         stage_o.b_bcd = AB_BCD_W'(dd_step(BCD_W'(stage_o.b_bcd), stage_o.b_bin[FIELD_AB_W-1]));
         stage_o.b_bin = {stage_o.b_bin[FIELD_AB_W-2:0], 1'b0};
      end
   end

endmodule

`default_nettype wire

FILE: hdl/bdf_format.sv
// places converted digits on the ten display positions per mode, with blanking
// depends on bdf_pkg
`default_nettype none

module bdf_format (
   input  bdf_pkg::conv_type   conv_i,
   output bdf_pkg::digits_type digit_o
);
   import bdf_pkg::*;

   logic higher_nz;
   logic blank_a;
   logic blank_b;
   logic blank_c;

   assign blank_a = conv_i.blink_phase && (conv_i.blink_sel == BLINK_A);
   assign blank_b = conv_i.blink_phase && (conv_i.blink_sel == BLINK_B);
   assign blank_c = conv_i.blink_phase && (conv_i.blink_sel == BLINK_C);

   always_comb begin
      higher_nz = 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         digit_o[i] = BLANK_CODE;
      end
      unique case (conv_i.kind)
         KIND_NUMBER: begin
            // leading zero blanking from the top digit down
            for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
               higher_nz = higher_nz | (conv_i.num_bcd[DIGIT_W*i +: DIGIT_W] != '0);
               digit_o[i] = higher_nz ? conv_i.num_bcd[DIGIT_W*i +: DIGIT_W] : BLANK_CODE;
            end
         end
         KIND_TIME: begin
            digit_o[1] = blank_c ? BLANK_CODE : conv_i.c_bcd[3:0];
            digit_o[2] = blank_c ? BLANK_CODE : conv_i.c_bcd[7:4];
            digit_o[4] = blank_b ? BLANK_CODE : conv_i.b_bcd[3:0];
            digit_o[5] = blank_b ? BLANK_CODE : conv_i.b_bcd[7:4];
            digit_o[7] = blank_a ? BLANK_CODE : conv_i.a_bcd[3:0];
            digit_o[8] = blank_a ? BLANK_CODE : conv_i.a_bcd[7:4];
         end
         KIND_DATE: begin
            digit_o[0] = blank_c ? BLANK_CODE : conv_i.c_bcd[3:0];
            digit_o[1] = blank_c ? BLANK_CODE : conv_i.c_bcd[7:4];
            digit_o[2] = blank_c ? BLANK_CODE : conv_i.c_bcd[11:8];
            digit_o[3] = blank_c ? BLANK_CODE : conv_i.c_bcd[15:12];
            digit_o[5] = blank_b ? BLANK_CODE : conv_i.b_bcd[3:0];
            digit_o[6] = blank_b ? BLANK_CODE : conv_i.b_bcd[7:4];
            digit_o[8] = blank_a ? BLANK_CODE : conv_i.a_bcd[3:0];
            digit_o[9] = blank_a ? BLANK_CODE : conv_i.a_bcd[7:4];
         end
         default: begin
            // unused kind code: all positions stay blank
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/bcd_display_formatter.sv
// ten-digit bcd display formatter: number, time and date modes with blanking
// an accepted item moves through pipe_ff[0] to pipe_ff[3] into the result register
// throughput: one item per cycle unless rsp_tready stalls the pipe; four shift-and-add-3
//   slices (7, 8, 8, 8 shifts of the 31-bit number lane) sit between their own registers
// reset: synchronous, active high; clears all stage valid bits, payload registers keep data
// depends on bdf_pkg, bdf_dabble_stage, bdf_format
`default_nettype none

module bcd_display_formatter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input items
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [30:0] number_value, [37:31] field_a, [44:38] field_b, [58:45] field_c,
   // [60:59] blink_select, [61] blink_phase, [63:62] zero
   input  wire logic [bdf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] kind
   input  wire logic [bdf_pkg::REQ_USER_W-1:0]  req_tuser,
   // result items
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [3:0] digit_0, [7:4] digit_1, ... [39:36] digit_9
   output logic [bdf_pkg::BCD_W-1:0]            rsp_tdata
);
   import bdf_pkg::*;

   localparam int STAGES = 4;

   // pipe_ff[0] is the input register, pipe_ff[1..3] hold partial conversions
   conv_type             pipe_ff [STAGES];
   conv_type             pipe_in [STAGES];
   conv_type             dab_out [STAGES];
   // valid_ff[STAGES] belongs to the result register
   logic [STAGES:0]      valid_ff;
   logic [STAGES:0]      valid_in;
   logic [STAGES:0]      stage_ready;
   digits_type           rsp_digits_ff;
   digits_type           rsp_digits_in;
   kind_type             rsp_kind_ff;

   // a stage takes new data when empty or when its contents move on
   always_comb begin
      stage_ready[STAGES] = !valid_ff[STAGES] || rsp_tready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = stage_ready[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k <= STAGES; k++) begin
         valid_in[k] = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign req_tready = stage_ready[0];

   // unpack the incoming item, bcd accumulators start at zero
   always_comb begin
      pipe_in[0]             = '0;
      pipe_in[0].kind        = kind_type'(req_tuser);
      pipe_in[0].num_bin     = req_tdata[30:0];
      pipe_in[0].a_bin       = req_tdata[37:31];
      pipe_in[0].b_bin       = req_tdata[44:38];
      pipe_in[0].c_bin       = req_tdata[58:45];
      pipe_in[0].blink_sel   = blink_type'(req_tdata[60:59]);
      pipe_in[0].blink_phase = req_tdata[61];
      for (int k = 1; k < STAGES; k++) begin
         pipe_in[k] = dab_out[k-1];
      end
   end

   // slice 0: small fields finish, seconds/year lane half done
   bdf_dabble_stage #(
      .NUM_SHIFTS (7),
      .C_SHIFTS   (7),
      .AB_SHIFTS  (FIELD_AB_W)
   ) u_stage0 (
      .stage_i (pipe_ff[0]),
      .stage_o (dab_out[0])
   );

   // slice 1: seconds/year lane finishes
   bdf_dabble_stage #(
      .NUM_SHIFTS (8),
      .C_SHIFTS   (FIELD_C_W - 7),
      .AB_SHIFTS  (0)
   ) u_stage1 (
      .stage_i (pipe_ff[1]),
      .stage_o (dab_out[1])
   );

   // slices 2 and 3: remaining bits of the number lane
   bdf_dabble_stage #(
      .NUM_SHIFTS (8),
      .C_SHIFTS   (0),
      .AB_SHIFTS  (0)
   ) u_stage2 (
      .stage_i (pipe_ff[2]),
      .stage_o (dab_out[2])
   );

   bdf_dabble_stage #(
      .NUM_SHIFTS (8),
      .C_SHIFTS   (0),
      .AB_SHIFTS  (0)
   ) u_stage3 (
      .stage_i (pipe_ff[3]),
      .stage_o (dab_out[3])
   );

   // digit placement and blanking right before the result register
   bdf_format u_format (
      .conv_i  (dab_out[STAGES-1]),
      .digit_o (rsp_digits_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (stage_ready[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
      if (stage_ready[STAGES]) begin
         rsp_digits_ff <= rsp_digits_in;
         rsp_kind_ff   <= dab_out[STAGES-1].kind;
      end
   end

   assign rsp_tvalid = valid_ff[STAGES];
   assign rsp_tdata  = rsp_digits_ff;

   // checks on the result register
   logic [DIGIT_COUNT-1:0] rsp_nonblank;
   logic                   rsp_bad_code;

   always_comb begin
      rsp_bad_code = 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         rsp_nonblank[i] = (rsp_digits_ff[i] != BLANK_CODE);
         rsp_bad_code    = rsp_bad_code ||
                           (rsp_nonblank[i] && (rsp_digits_ff[i] > 4'd9));
      end
   end

   // every shown code is a decimal digit or blank
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_bad_code)
      else $error("non-decimal digit code on result");

   // number mode blanks only a contiguous run of top digits
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_kind_ff == KIND_NUMBER)) |->
         ((rsp_nonblank & (rsp_nonblank + 10'd1)) == '0))
      else $error("blank digit below a shown digit in number mode");

   // time mode separator positions are always blank
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_kind_ff == KIND_TIME)) |->
         (!rsp_nonblank[0] && !rsp_nonblank[3] && !rsp_nonblank[6] && !rsp_nonblank[9]))
      else $error("separator position shown in time mode");

   // unused kind code gives an all-blank display
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_kind_ff != KIND_NUMBER) && (rsp_kind_ff != KIND_TIME) &&
       (rsp_kind_ff != KIND_DATE)) |-> (rsp_nonblank == '0))
      else $error("digit shown for unused kind");

endmodule

`default_nettype wire
